// ===== hw/rtl/greedy_height_map_path_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the greedy path RTL
// Clocked on clk, quiet while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef GREEDY_HEIGHT_MAP_PATH_MACROS_SVH
`define GREEDY_HEIGHT_MAP_PATH_MACROS_SVH

// Implication within the same cycle
`define GHMP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle
`define GHMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ghmp_pkg.sv =====
// ---------------------------------------------------------------------------
// ghmp_pkg
// Types and codes of the greedy height map path block.
// ---------------------------------------------------------------------------
package ghmp_pkg;

    // Input item opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_WALK = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_ROWS    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_COLS    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PAINT_RED   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PAINT_GREEN = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_PAINT_BLUE  = 3'd4;
    localparam int CFG_DATA_BITS = 8;

    // Fixed field widths
    localparam int DIM_BITS   = 7;
    localparam int ROWF_BITS  = 6;
    localparam int COL_BITS   = 6;
    localparam int STEP_BITS  = 16;
    localparam int TOTAL_BITS = 23;
    localparam int TOUT_BITS  = 22;

    typedef struct packed {
        logic        opcode;
        logic [15:0] height;
        logic [5:0]  entry_row;
    } cmd_t;

    typedef struct packed {
        logic [5:0]  path_row;
        logic [5:0]  path_col;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] step_dist;
        logic [21:0] run_total;
        logic        last;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HERE,
        ST_NBR,
        ST_PICK
    } state_t;

endpackage

// ===== hw/rtl/greedy_height_map_path.sv =====
// ---------------------------------------------------------------------------
// greedy_height_map_path
// Height map store with a greedy lowest-change walk across its columns.
// ---------------------------------------------------------------------------
// A load command (busy low) writes one height in row-major order. A walk
// command keeps busy high while it runs: the start state reads the start
// cell, then for each column a neighbor state reads its three right-hand
// neighbors (two copies of the map, three read ports) and a pick state
// compares the height changes. One result is strobed on result_valid per
// column, every other cycle, and must be taken as it comes;
// the final one carries last. Config writes belong to idle periods.
// ---------------------------------------------------------------------------
`include "greedy_height_map_path_macros.svh"

module greedy_height_map_path
    import ghmp_pkg::*;
#(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLS    = 64,
    parameter int HEIGHT_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  cmd_t                     cmd,
    output logic                     result_valid,
    output result_t                  result,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int HW    = HEIGHT_BITS;

    // Configuration registers
    logic [DIM_BITS-1:0] num_rows_reg, num_cols_reg;
    logic [7:0]          paint_red_reg, paint_green_reg, paint_blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg    <= 7'd64;
            num_cols_reg    <= 7'd64;
            paint_red_reg   <= '0;
            paint_green_reg <= '0;
            paint_blue_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NUM_ROWS:    num_rows_reg    <= cfg_data[DIM_BITS-1:0];
                REG_NUM_COLS:    num_cols_reg    <= cfg_data[DIM_BITS-1:0];
                REG_PAINT_RED:   paint_red_reg   <= cfg_data;
                REG_PAINT_GREEN: paint_green_reg <= cfg_data;
                REG_PAINT_BLUE:  paint_blue_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Map size in use, zero reads as one, capped at the store size
    logic [DIM_BITS-1:0] rows_eff, cols_eff, rows_m1;
    logic [AW:0]         map_size;

    always_comb
    begin
        if (num_rows_reg == '0)
            rows_eff = 7'd1;
        else if (32'(num_rows_reg) > MAX_ROWS)
            rows_eff = DIM_BITS'(MAX_ROWS);
        else
            rows_eff = num_rows_reg;
        if (num_cols_reg == '0)
            cols_eff = 7'd1;
        else if (32'(num_cols_reg) > MAX_COLS)
            cols_eff = DIM_BITS'(MAX_COLS);
        else
            cols_eff = num_cols_reg;
        rows_m1  = rows_eff - 7'd1;
        map_size = (AW+1)'(rows_eff * cols_eff);
    end

    // State
    state_t              state_reg, state_next;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic [DIM_BITS-1:0] row_reg;
    logic [COL_BITS-1:0] col_reg;
    logic [AW-1:0]       addr_reg;
    logic [HW-1:0]       here_reg;
    logic [TOTAL_BITS-1:0] total_reg;
    result_t             result_reg;
    logic                result_valid_reg;

    // Accept decode
    logic accept, do_load, do_walk;
    assign accept  = start && (state_reg == ST_IDLE);
    assign do_load = accept && (cmd.opcode == OP_LOAD);
    assign do_walk = accept && (cmd.opcode == OP_WALK);

    // Load pointer with wrap at the map size in use
    logic [AW-1:0] load_addr;
    logic [AW:0]   load_inc;

    always_comb
    begin
        load_addr = ({1'b0, ptr_reg} < map_size) ? ptr_reg : '0;
        load_inc  = {1'b0, load_addr} + (AW+1)'(1);
        ptr_next  = (load_inc >= map_size) ? '0 : load_inc[AW-1:0];
    end

    // Start cell: clamp the row, base address of row in column 0
    logic [DIM_BITS-1:0] entry_row_clamped;
    logic [AW-1:0]       start_addr;

    always_comb
    begin
        if ({1'b0, cmd.entry_row} > rows_m1)
            entry_row_clamped = rows_m1;
        else
            entry_row_clamped = {1'b0, cmd.entry_row};
        start_addr = AW'(entry_row_clamped * cols_eff);
    end

    // Neighbor addresses; off-map rows fall back to straight ahead
    logic          has_up, has_down, is_last;
    logic [AW-1:0] mid_addr, up_addr, down_addr;

    always_comb
    begin
        has_up    = (row_reg != '0);
        has_down  = ({1'b0, row_reg} + 8'd1) < {1'b0, rows_eff};
        is_last   = (col_reg == COL_BITS'(cols_eff - 7'd1));
        mid_addr  = addr_reg + AW'(1);
        up_addr   = has_up   ? (mid_addr - AW'(cols_eff)) : mid_addr;
        down_addr = has_down ? (mid_addr + AW'(cols_eff)) : mid_addr;
    end

    // Height map: two copies, both written on load; copy A has two reads
    logic [HW-1:0] mem_a [DEPTH];
    logic [HW-1:0] mem_b [DEPTH];
    logic [HW-1:0] rd_mid_reg, rd_up_reg, rd_down_reg;
    logic [AW-1:0] rd_mid_addr;

    assign rd_mid_addr = (state_reg == ST_HERE) ? addr_reg : mid_addr;

    always_ff @(posedge clk)
    begin
        if (do_load)
            mem_a[load_addr] <= HW'(cmd.height);
        rd_mid_reg <= mem_a[rd_mid_addr];
        rd_up_reg  <= mem_a[up_addr];
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
            mem_b[load_addr] <= HW'(cmd.height);
        rd_down_reg <= mem_b[down_addr];
    end

    // Height changes and greedy choice
    logic [HW-1:0] d_mid, d_up, d_down, step_sel;
    logic          go_down, go_up;
    logic [STEP_BITS-1:0]  step_out;
    logic [TOTAL_BITS-1:0] total_next;

    always_comb
    begin
        d_mid  = (rd_mid_reg  > here_reg) ? rd_mid_reg  - here_reg : here_reg - rd_mid_reg;
        d_up   = (rd_up_reg   > here_reg) ? rd_up_reg   - here_reg : here_reg - rd_up_reg;
        d_down = (rd_down_reg > here_reg) ? rd_down_reg - here_reg : here_reg - rd_down_reg;
        go_down = has_down && (d_down < d_mid) && (!has_up || d_down <= d_up);
        go_up   = !go_down && has_up && (d_up < d_mid) && (!has_down || d_up < d_down);
        if (go_down)
            step_sel = d_down;
        else if (go_up)
            step_sel = d_up;
        else
            step_sel = d_mid;
        // no move is taken from the last column; the total adds no change there
        step_out   = is_last ? '0 : STEP_BITS'(step_sel);
        total_next = total_reg + (is_last ? '0 : TOTAL_BITS'(step_sel));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (do_walk) state_next = ST_HERE;
            ST_HERE: state_next = ST_NBR;
            ST_NBR:  state_next = ST_PICK;
            ST_PICK: state_next = is_last ? ST_IDLE : ST_NBR;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            ptr_reg          <= '0;
            row_reg          <= '0;
            total_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= (state_reg == ST_PICK);
            if (do_load)
                ptr_reg <= ptr_next;
            if (do_walk)
            begin
                row_reg   <= entry_row_clamped;
                total_reg <= '0;
            end
            else if (state_reg == ST_PICK)
            begin
                total_reg <= total_next;
                if (!is_last && go_down)
                    row_reg <= row_reg + 7'd1;
                else if (!is_last && go_up)
                    row_reg <= row_reg - 7'd1;
            end
        end
    end

    // Walk datapath and result register
    always_ff @(posedge clk)
    begin
        if (do_walk)
        begin
            addr_reg <= start_addr;
            col_reg  <= '0;
        end
        if (state_reg == ST_NBR && col_reg == '0)
            here_reg <= rd_mid_reg;
        if (state_reg == ST_PICK)
        begin
            result_reg.path_row  <= row_reg[ROWF_BITS-1:0];
            result_reg.path_col  <= col_reg;
            result_reg.red       <= paint_red_reg;
            result_reg.green     <= paint_green_reg;
            result_reg.blue      <= paint_blue_reg;
            result_reg.step_dist <= step_out;
            result_reg.run_total <= total_next[TOUT_BITS-1:0];
            result_reg.last      <= is_last;
            col_reg <= col_reg + COL_BITS'(1);
            if (go_down)
            begin
                addr_reg <= down_addr;
                here_reg <= rd_down_reg;
            end
            else if (go_up)
            begin
                addr_reg <= up_addr;
                here_reg <= rd_up_reg;
            end
            else
            begin
                addr_reg <= mid_addr;
                here_reg <= rd_mid_reg;
            end
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Checks
    `GHMP_ASSERT_NEXT(a_strobe_single, result_valid, !result_valid,
        "result strobes must be at least two cycles apart")
    `GHMP_ASSERT_NOW(a_last_frees_block, result_valid && result.last, !busy,
        "block still busy when the last result is shown")
    `GHMP_ASSERT_NEXT(a_walk_continues, result_valid && !result.last, busy,
        "walk stopped before its last column")

endmodule

// ===== bench/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for greedy_height_map_path. Commands are sent on the
// start/busy handshake. Every accepted command is also run through a local
// model of the height map and the greedy walk, and each strobed result is
// compared field by field with the oldest predicted path cell.
// ---------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ghmp_pkg::*;

    localparam int MAP_MAX        = 64;
    localparam int MAP_DEPTH      = MAP_MAX * MAP_MAX;
    localparam int MAP_AW         = $clog2(MAP_DEPTH);
    localparam int RAND_ITEMS     = 160;
    localparam int WATCHDOG_LIMIT = 1000;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    cmd_t                     cmd;
    logic                     result_valid;
    result_t                  result;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    // Local copy of the map, load pointer and registers (reset values)
    bit [15:0]   heights_mdl [MAP_DEPTH];
    int unsigned load_ptr_mdl = 0;
    bit [6:0]    rows_cfg     = 7'd64;
    bit [6:0]    cols_cfg     = 7'd64;
    bit [7:0]    red_cfg      = 8'd0;
    bit [7:0]    green_cfg    = 8'd0;
    bit [7:0]    blue_cfg     = 8'd0;

    result_t     path_cells_q [$];
    int          fail_cnt     = 0;
    int          sent_items   = 0;
    bit          gap_en       = 1'b1;

    greedy_height_map_path i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Path prediction
    // ------------------------------------------------------------------

    // 0 acts as 1, anything above the map maximum saturates
    function automatic int unsigned eff_dim(bit [6:0] v);
        if (v == 0)
            return 1;
        if (v > MAP_MAX)
            return MAP_MAX;
        return 32'(v);
    endfunction

    function automatic int unsigned height_delta(int unsigned a, int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int unsigned map_at(int unsigned addr);
        return 32'(heights_mdl[MAP_AW'(addr)]);
    endfunction

    function automatic void predict_cmd(cmd_t c);
        int unsigned rows, cols, size, addr, row, col;
        int unsigned here, mid, up, dn, stepv, total;
        bit          has_up, has_dn;
        result_t     r;
        rows = eff_dim(rows_cfg);
        cols = eff_dim(cols_cfg);
        size = rows * cols;

        // load: row-major write, pointer past the map restarts at cell 0
        if (c.opcode == OP_LOAD)
        begin
            addr = (load_ptr_mdl < size) ? load_ptr_mdl : 0;
            heights_mdl[MAP_AW'(addr)] = c.height;
            addr++;
            load_ptr_mdl = (addr >= size) ? 0 : addr;
            return;
        end

        // walk: start row clamps to the bottom row
        row = 32'(c.entry_row);
        if (row > rows - 1)
            row = rows - 1;
        total = 0;
        for (col = 0; col < cols; col++)
        begin
            r.path_row = row[5:0];
            r.path_col = col[5:0];
            r.red      = red_cfg;
            r.green    = green_cfg;
            r.blue     = blue_cfg;
            stepv      = 0;
            if (col != cols - 1)
            begin
                here   = map_at(row * cols + col);
                mid    = height_delta(map_at(row * cols + col + 1), here);
                has_up = (row > 0);
                has_dn = (row + 1 < rows);
                up     = has_up ? height_delta(map_at((row - 1) * cols + col + 1), here)
                                : 0;
                dn     = has_dn ? height_delta(map_at((row + 1) * cols + col + 1), here)
                                : 0;
                // straight wins ties, down wins an up/down tie
                if (has_dn && dn < mid && (!has_up || dn <= up))
                begin
                    stepv = dn;
                    row++;
                end
                else if (has_up && up < mid && (!has_dn || up < dn))
                begin
                    stepv = up;
                    row--;
                end
                else
                begin
                    stepv = mid;
                end
                total = (total + stepv) & 32'h7F_FFFF;
            end
            r.step_dist = stepv[15:0];
            r.run_total = total[21:0];
            r.last      = (col == cols - 1);
            path_cells_q.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid)
        begin
            if (path_cells_q.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %p", $time, result);
                fail_cnt++;
            end
            else
            begin
                want = path_cells_q.pop_front();
                check_field("path_row", 32'(want.path_row), 32'(result.path_row));
                check_field("path_col", 32'(want.path_col), 32'(result.path_col));
                check_field("red", 32'(want.red), 32'(result.red));
                check_field("green", 32'(want.green), 32'(result.green));
                check_field("blue", 32'(want.blue), 32'(result.blue));
                check_field("step_dist", 32'(want.step_dist), 32'(result.step_dist));
                check_field("run_total", 32'(want.run_total), 32'(result.run_total));
                check_field("last", 32'(want.last), 32'(result.last));
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || result_valid || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // One command transfer; start stays high unless a gap follows
    task automatic send_cmd(input cmd_t c);
        int gap;
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        predict_cmd(c);
        sent_items++;
        gap = 0;
        if (gap_en && $urandom_range(0, 99) < 9)
            gap = $urandom_range(1, 4);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic load_height(input bit [15:0] h);
        cmd_t c;
        c.opcode    = OP_LOAD;
        c.height    = h;
        c.entry_row = 6'($urandom);
        send_cmd(c);
    endtask

    task automatic walk_from(input bit [5:0] srow);
        cmd_t c;
        c.opcode    = OP_WALK;
        c.height    = 16'($urandom);
        c.entry_row = srow;
        send_cmd(c);
    endtask

    // Hold off until every predicted cell has come and the block is idle
    task automatic wait_idle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (path_cells_q.size() != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_NUM_ROWS:    rows_cfg  = data[6:0];
            REG_NUM_COLS:    cols_cfg  = data[6:0];
            REG_PAINT_RED:   red_cfg   = data;
            REG_PAINT_GREEN: green_cfg = data;
            REG_PAINT_BLUE:  blue_cfg  = data;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_map(input bit [7:0] rows, input bit [7:0] cols);
        write_reg(REG_NUM_ROWS, rows);
        write_reg(REG_NUM_COLS, cols);
    endtask

    task automatic set_paint(input bit [7:0] r, input bit [7:0] g, input bit [7:0] b);
        write_reg(REG_PAINT_RED, r);
        write_reg(REG_PAINT_GREEN, g);
        write_reg(REG_PAINT_BLUE, b);
    endtask

    // mode 0: narrow band (many ties), 1: full range, else near the extremes
    function automatic bit [15:0] rand_height(int mode);
        case (mode)
            0:       return 16'($urandom_range(100, 104));
            1:       return 16'($urandom_range(0, 65535));
            default: return ($urandom_range(0, 1) != 0) ? 16'(16'hFFFF - $urandom_range(0, 2))
                                                        : 16'($urandom_range(0, 2));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset geometry is 64x64 with black paint; row 0 is flat so the walk
    // stays on it and only rows 0 and 1 are read
    task automatic test_reset_config();
        bit [15:0] flat_h;
        int        i;
        flat_h = 16'($urandom);
        for (i = 0; i < 2 * MAP_MAX; i++)
            load_height((i < MAP_MAX) ? flat_h : rand_height(i % 3));
        walk_from(6'd0);
    endtask

    // Zero sizes act as a 1x1 map; start row clamps to row 0
    task automatic test_single_cell();
        wait_idle();
        set_map(8'd0, 8'd0);
        set_paint(8'd255, 8'd0, 8'd170);
        load_height(16'hFFFF);
        walk_from(6'd63);
    endtask

    // Straight-ahead ties and an up/down tie on a 3x3 map
    task automatic test_tie_breaks();
        bit [15:0] tie_map [9] = '{16'd100, 16'd102, 16'd95,
                                   16'd100, 16'd98,  16'd110,
                                   16'd100, 16'd102, 16'd101};
        wait_idle();
        set_map(8'd3, 8'd3);
        foreach (tie_map[k])
            load_height(tie_map[k]);
        walk_from(6'd1);
        walk_from(6'd0);
        walk_from(6'd2);
        walk_from(6'd63);
    endtask

    // Pointer left past a shrunken map restarts at cell 0; extreme heights
    task automatic test_load_wrap();
        int i;
        for (i = 0; i < 5; i++)
            load_height(rand_height(1));
        wait_idle();
        set_map(8'd2, 8'd2);
        load_height(16'h0000);
        load_height(16'hFFFF);
        load_height(16'hFFFF);
        load_height(16'h0000);
        walk_from(6'd0);
        walk_from(6'd1);
    endtask

    // Oversized sizes saturate; single row and single column maps.
    // Runs while the flat row 0 of the reset fill is still in place.
    task automatic test_saturated_dims();
        wait_idle();
        set_map(8'hFF, 8'd100);
        set_paint(8'd0, 8'd255, 8'd0);
        walk_from(6'd0);
        wait_idle();
        write_reg(REG_NUM_ROWS, 8'd1);
        walk_from(6'd17);
        wait_idle();
        set_map(8'd64, 8'd1);
        walk_from(6'd40);
    endtask

    // Random phases: new geometry and paint, a full fill, then mixed traffic
    task automatic test_random_walks();
        int        first, phase, n, i, size, mode;
        bit [7:0]  rv, cv;
        first = sent_items;
        phase = 0;
        while (sent_items - first < RAND_ITEMS)
        begin
            wait_idle();
            // phase 1 sends its commands with no random gaps and no drain waits
            gap_en = (phase != 1);
            case ($urandom_range(0, 9))
                0:       rv = 8'd0;
                1:       rv = 8'($urandom_range(9, 255));
                default: rv = 8'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 9))
                0:       cv = 8'd0;
                1:       cv = 8'($urandom_range(13, 255));
                default: cv = 8'($urandom_range(1, 12));
            endcase
            // keep the map small enough to be filled completely
            size = eff_dim(rv[6:0]) * eff_dim(cv[6:0]);
            if (size > 96)
            begin
                if ($urandom_range(0, 1) != 0)
                    cv = 8'd1;
                else
                    rv = 8'd1;
                size = eff_dim(rv[6:0]) * eff_dim(cv[6:0]);
            end
            set_map(rv, cv);
            set_paint(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
            mode = $urandom_range(0, 2);
            for (i = 0; i < size; i++)
                load_height(rand_height(mode));
            n = $urandom_range(10, 30);
            for (i = 0; i < n; i++)
            begin
                // occasionally let every pending path cell drain first
                if (gap_en && $urandom_range(0, 99) < 3)
                    wait_idle();
                if ($urandom_range(0, 99) < 55)
                    walk_from(($urandom_range(0, 1) != 0)
                              ? 6'($urandom_range(0, eff_dim(rv[6:0]) - 1))
                              : 6'($urandom_range(0, 63)));
                else
                    load_height(rand_height(mode));
            end
            phase++;
        end
        gap_en = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     <= 1'b0;
        start     <= 1'b0;
        cmd       <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_saturated_dims();
        test_single_cell();
        test_tie_breaks();
        test_load_wrap();
        test_random_walks();

        wait_idle();
        repeat (8) @(posedge clk);
        if (fail_cnt == 0 && path_cells_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/ghmp_pkg.sv
hw/rtl/greedy_height_map_path.sv
bench/testbench.sv
